>>> sv/dgt_pkg.sv
// ============================================================================
// dgt_pkg
// Shared constants, mode codes and controller/datapath interface structs for
// the distortion grid table.
// ============================================================================
package dgt_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_INV   = 2'd2;

    localparam int MODE_W     = 2;
    localparam int GRID_IDX_W = 6;              // width of the grid_i / grid_j fields
    localparam int COORD_W    = 16;             // Q2.14
    localparam int Q_FRAC     = 14;
    localparam int Q_ONE      = 16384;
    localparam int Q_HALF     = 8192;
    localparam int ENTRY_W    = 2 * COORD_W;    // y in upper half, x in lower half
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;    // |diff| < 2^16, square < 2^32
    localparam int DIST_W     = SQ_W + 1;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch input word
        logic mem_write;    // store entry
        logic fwd_read;     // read entry at forward address
        logic scan_clear;   // restart scan counters and best tracker
        logic scan_read;    // read next entry of the scan
        logic out_load;     // load output register
    } dgt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              write_ok;
        logic              fwd_ok;
        logic              scan_last;
        logic              pipe_busy;
    } dgt_sts_t;

endpackage

>>> sv/distortion_grid_table.sv
// ============================================================================
// distortion_grid_table
// Grid of distorted Q2.14 points with entry write, forward lookup and inverse
// nearest-entry search.
// ============================================================================
// The block holds (GRID_RES+1)^2 entries in one single-port memory, entry
// (i,j) holding the distorted point of grid coordinate (i/GRID_RES,
// j/GRID_RES) as signed Q2.14 x and y. One input word gives exactly one
// result word and the block works on one word at a time. A write or a
// forward lookup goes through capture, then memory access, then output
// load, and the load waits for the output register to be free. An
// inverse search reads every entry once through the memory read port, one
// entry per cycle, row outer, then drains a four-stage distance pipeline
// before its result is loaded. A finished result sits in the output
// register until taken while the next input word is already accepted;
// that word's result waits for the register to free up. The memory has no
// reset or clearing pass: an entry that was never written reads as garbage,
// so every entry must be written before an inverse search, and a forward
// lookup must only hit written entries. Ties in the search go to the first
// entry in scan order.
// ============================================================================
module distortion_grid_table
    import dgt_pkg::*;
#(
    parameter int GRID_RES = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input words
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [MODE_W-1:0]         s_mode,
    input  logic [GRID_IDX_W-1:0]     s_grid_i,
    input  logic [GRID_IDX_W-1:0]     s_grid_j,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    // result words
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_result_x,
    output logic signed [COORD_W-1:0] m_result_y,
    output logic                      m_status,
    output logic                      m_off_grid
);

    dgt_cmd_t cmd;
    dgt_sts_t sts;

    // sequencer: handshakes, mode decode, scan and drain
    dgt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // memory, index math, distance pipeline and output register
    dgt_datapath #(
        .GRID_RES (GRID_RES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (s_mode),
        .in_grid_i    (s_grid_i),
        .in_grid_j    (s_grid_j),
        .in_coord_x   (s_coord_x),
        .in_coord_y   (s_coord_y),
        .out_result_x (m_result_x),
        .out_result_y (m_result_y),
        .out_status   (m_status),
        .out_off_grid (m_off_grid)
    );

endmodule

>>> sv/dgt_datapath.sv
// ============================================================================
// dgt_datapath
// Query registers, grid memory, forward index math, pipelined distance scan
// and output register.
// ============================================================================
module dgt_datapath
    import dgt_pkg::*;
#(
    parameter int GRID_RES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dgt_cmd_t                     cmd,
    output dgt_sts_t                     sts,
    input  logic [MODE_W-1:0]            in_mode,
    input  logic [GRID_IDX_W-1:0]        in_grid_i,
    input  logic [GRID_IDX_W-1:0]        in_grid_j,
    input  logic signed [COORD_W-1:0]    in_coord_x,
    input  logic signed [COORD_W-1:0]    in_coord_y,
    output logic signed [COORD_W-1:0]    out_result_x,
    output logic signed [COORD_W-1:0]    out_result_y,
    output logic                         out_status,
    output logic                         out_off_grid
);

    localparam int GRID_SIDE  = GRID_RES + 1;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W      = $clog2(GRID_SIDE);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int LUT_DEPTH  = 1 << IDX_W;
    localparam int P_W        = COORD_W + IDX_W;
    localparam int Q_W        = P_W - Q_FRAC;
    localparam int CMP_W      = (IDX_W > GRID_IDX_W) ? IDX_W : GRID_IDX_W;

    // ---- query registers ----
    logic [MODE_W-1:0]         mode_reg;
    logic [GRID_IDX_W-1:0]     gi_reg, gj_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= in_mode;
            gi_reg   <= in_grid_i;
            gj_reg   <= in_grid_j;
            qx_reg   <= in_coord_x;
            qy_reg   <= in_coord_y;
        end
    end

    // ---- grid coordinate table: k/GRID_RES rounded half up, Q2.14 ----
    logic [COORD_W-1:0] coord_lut [LUT_DEPTH];

    for (genvar k = 0; k < LUT_DEPTH; k++) begin : g_lut
        localparam int LutVal = (k <= GRID_RES) ? (k * Q_ONE + GRID_RES / 2) / GRID_RES : 0;
        assign coord_lut[k] = COORD_W'(LutVal);
    end

    // ---- write range check and address ----
    logic              write_ok;
    logic [ADDR_W-1:0] wr_addr;

    assign write_ok = (CMP_W'(gi_reg) <= CMP_W'(GRID_RES)) &&
                      (CMP_W'(gj_reg) <= CMP_W'(GRID_RES));
    assign wr_addr  = ADDR_W'(gi_reg) * ADDR_W'(GRID_SIDE) + ADDR_W'(gj_reg);

    // ---- forward index: round(coord*GRID_RES / 2^14), halves away from zero ----
    logic signed [COORD_W-1:0] fq [2];
    logic signed [P_W-1:0]     prod [2];
    logic [P_W-1:0]            mag [2];
    logic [P_W-1:0]            rsum [2];
    logic [Q_W-1:0]            qidx [2];
    logic                      in_rng [2];
    logic [IDX_W-1:0]          fidx [2];
    logic                      fwd_ok;
    logic [ADDR_W-1:0]         fwd_addr;

    assign fq[0] = qx_reg;
    assign fq[1] = qy_reg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            prod[a]   = P_W'(fq[a]) * P_W'(GRID_RES);
            mag[a]    = prod[a][P_W-1] ? P_W'(-prod[a]) : P_W'(prod[a]);
            rsum[a]   = mag[a] + P_W'(Q_HALF);
            qidx[a]   = rsum[a][P_W-1:Q_FRAC];
            // a small negative query that rounds to zero is still on the grid
            in_rng[a] = !(prod[a][P_W-1] && (qidx[a] != '0)) &&
                        (qidx[a] <= Q_W'(GRID_RES));
            fidx[a]   = IDX_W'(qidx[a]);
        end
    end

    assign fwd_ok   = in_rng[0] && in_rng[1];
    assign fwd_addr = ADDR_W'(fidx[0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(fidx[1]);

    // ---- scan counters, row outer ----
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              scan_last;

    assign scan_last = (row_reg == IDX_W'(GRID_RES)) && (col_reg == IDX_W'(GRID_RES));

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        addr_next = addr_reg;
        if (cmd.scan_clear) begin
            row_next  = '0;
            col_next  = '0;
            addr_next = '0;
        end else if (cmd.scan_read) begin
            addr_next = addr_reg + ADDR_W'(1);
            if (col_reg == IDX_W'(GRID_RES)) begin
                col_next = '0;
                row_next = row_reg + IDX_W'(1);
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        addr_reg <= addr_next;
    end

    // ---- grid memory, registered read ----
    logic [ENTRY_W-1:0] grid_mem [GRID_CELLS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;

    assign rd_addr = cmd.fwd_read ? fwd_addr : addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            grid_mem[wr_addr] <= {qy_reg, qx_reg};
        end
        if (cmd.fwd_read || cmd.scan_read) begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // ---- scan pipeline: read -> diff -> square -> compare ----
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IDX_W-1:0]         s1_i_reg, s1_j_reg, s2_i_reg, s2_j_reg, s3_i_reg, s3_j_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [DIST_W-1:0]        dist_sum;
    logic [DIST_W-1:0]        best_reg;
    logic [IDX_W-1:0]         best_i_reg, best_j_reg;
    logic                     first_reg;
    logic                     take_best;

    assign dx_next  = DIFF_W'($signed(rd_data_reg[COORD_W-1:0])) - DIFF_W'(qx_reg);
    assign dy_next  = DIFF_W'($signed(rd_data_reg[ENTRY_W-1:COORD_W])) - DIFF_W'(qy_reg);
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    // first entry always wins; later ones only on a strict improvement
    assign take_best = s3_valid_reg && (first_reg || (dist_sum < best_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            first_reg    <= 1'b1;
        end else begin
            s1_valid_reg <= cmd.scan_read;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.scan_clear) begin
                first_reg <= 1'b1;
            end else if (take_best) begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_i_reg <= row_reg;
        s1_j_reg <= col_reg;
        s2_i_reg <= s1_i_reg;
        s2_j_reg <= s1_j_reg;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        s3_i_reg <= s2_i_reg;
        s3_j_reg <= s2_j_reg;
        sqx_reg  <= sqx_full[SQ_W-1:0];
        sqy_reg  <= sqy_full[SQ_W-1:0];
        if (take_best) begin
            best_reg   <= dist_sum;
            best_i_reg <= s3_i_reg;
            best_j_reg <= s3_j_reg;
        end
    end

    // ---- result select and output register ----
    logic signed [COORD_W-1:0] res_x, res_y;
    logic                      res_status, res_off;

    always_comb begin
        res_x      = '0;
        res_y      = '0;
        res_status = 1'b0;
        res_off    = 1'b0;
        case (mode_reg)
            MODE_WRITE: begin
                res_status = !write_ok;
            end
            MODE_FWD: begin
                if (fwd_ok) begin
                    res_x   = $signed(rd_data_reg[COORD_W-1:0]);
                    res_y   = $signed(rd_data_reg[ENTRY_W-1:COORD_W]);
                    res_off = (coord_lut[fidx[0]] != qx_reg) ||
                              (coord_lut[fidx[1]] != qy_reg);
                end else begin
                    res_status = 1'b1;
                end
            end
            MODE_INV: begin
                res_x = $signed(coord_lut[best_i_reg]);
                res_y = $signed(coord_lut[best_j_reg]);
            end
            default: begin
                res_x = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_result_x <= res_x;
            out_result_y <= res_y;
            out_status   <= res_status;
            out_off_grid <= res_off;
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.write_ok  = write_ok;
    assign sts.fwd_ok    = fwd_ok;
    assign sts.scan_last = scan_last;
    assign sts.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule

>>> sv/dgt_ctrl.sv
// ============================================================================
// dgt_ctrl
// Sequencer for write, forward lookup and inverse scan; owns both handshakes.
// ============================================================================
module dgt_ctrl
    import dgt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output dgt_cmd_t cmd,
    input  dgt_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.mode)
                    MODE_WRITE: begin
                        cmd.mem_write = sts.write_ok;
                        state_next    = ST_FINISH;
                    end
                    MODE_FWD: begin
                        cmd.fwd_read = sts.fwd_ok;
                        state_next   = ST_FINISH;
                    end
                    MODE_INV: begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_read = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_mem_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write |-> !(cmd.fwd_read || cmd.scan_read))
        else $error("grid write collides with a read");

    a_last_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && sts.scan_last |=> sts.pipe_busy)
        else $error("last scan entry missing from pipeline");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.pipe_busy)
        else $error("scan data still in flight while idle");

    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid && (state_reg == ST_IDLE))
        else $error("result load did not present a word");
`endif

endmodule
